// ===== rtl/sha256_pkg.sv =====
// ============================================================================
// sha256_pkg
// Shared types, constants and round tables for the SHA-256 message hasher.
// ============================================================================
package sha256_pkg;

    localparam int WORD_W  = 32;
    localparam int LEN_W   = 64;
    localparam int ROUNDS  = 64;
    localparam int BLK_WDS = 16;

    localparam logic [WORD_W-1:0] PAD_MARK_WORD = 32'h8000_0000;

    localparam logic [WORD_W-1:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Source of the word shifted into the block buffer
    typedef enum logic [2:0] {
        PUSH_DATA,
        PUSH_PAD,
        PUSH_MARK,
        PUSH_ZERO,
        PUSH_LEN_HI,
        PUSH_LEN_LO
    } t_push_src;

    typedef struct packed {
        logic       push;
        t_push_src  push_src;
        logic       len_en;
        logic [2:0] len_bytes;
        logic       init_vars;
        logic       round_en;
        logic [5:0] round_idx;
        logic       chain_add;
        logic       chain_reset;
        logic [2:0] out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_is_14;
        logic fill_is_15;
    } t_dp_stat;

endpackage

// ===== rtl/sha256_in_if.sv =====
// ============================================================================
// sha256_in_if
// Message word channel: valid/ready handshake with the message word payload.
// ============================================================================
interface sha256_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_of_message;

    modport source (output valid, output data_word, output valid_bytes,
                    output last_of_message, input ready);
    modport sink   (input valid, input data_word, input valid_bytes,
                    input last_of_message, output ready);
endinterface

// ===== rtl/sha256_out_if.sv =====
// ============================================================================
// sha256_out_if
// Digest channel: valid/ready handshake carrying one digest word per transaction.
// ============================================================================
interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ===== rtl/sha256_message_hasher.sv =====
// ============================================================================
// sha256_message_hasher
// SHA-256 over a byte message delivered as 32-bit words, digest out as 8 words.
// ============================================================================
// Send the message as 32-bit words, first byte in bits 31..24; every word is
// four bytes except the one flagged last_of_message, whose valid_bytes (0..4,
// larger values count as 4) gives its leading valid bytes. The sixteenth word
// of a block holds off the input while the single round unit runs its 64
// rounds, one per cycle, and then the chaining add. After the last word the
// block pads internally, one word per cycle except while a filled block is
// compressed, compresses one final block, or two when fewer than two words are
// left for the length, and then offers the digest as eight transactions, word 0
// (most significant) first, the eighth flagged last_word. No new message word
// is taken until the eighth digest transaction completes; the hasher then
// starts over from the initial chaining value with a zero length.
module sha256_message_hasher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha256_in_if.sink    i_msg,
    sha256_out_if.source o_dig
);
    import sha256_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_stat   dp_stat;
    logic       in_ready;
    logic       out_valid;
    logic [2:0] out_idx;
    logic [31:0] digest_word;

    // Sequencer: accepts words, drives padding, counts rounds, walks the digest
    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_msg.valid),
        .i_last       (i_msg.last_of_message),
        .i_valid_bytes(i_msg.valid_bytes),
        .o_in_ready   (in_ready),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_dig.ready),
        .o_out_idx    (out_idx),
        .o_cmd        (dp_cmd),
        .i_stat       (dp_stat)
    );

    // Datapath: block buffer / schedule window, round unit, chain and length
    sha256_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_data_word  (i_msg.data_word),
        .i_valid_bytes(i_msg.valid_bytes),
        .o_digest_word(digest_word)
    );

    // Hold the digest word steady from the chain registers until taken
    assign i_msg.ready       = in_ready;
    assign o_dig.valid       = out_valid;
    assign o_dig.digest_word = digest_word;
    assign o_dig.word_index  = out_idx;
    assign o_dig.last_word   = (out_idx == 3'd7);

endmodule

// ===== rtl/sha256_ctrl.sv =====
// ============================================================================
// sha256_ctrl
// Sequencer: message intake, padding, round count and digest readout.
// ============================================================================
module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_last,
    input  logic [2:0]          i_valid_bytes,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_out_idx,
    output sha256_pkg::t_dp_cmd o_cmd,
    input  sha256_pkg::t_dp_stat i_stat
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_LENLO,
        S_ROUNDS,
        S_UPDATE,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    t_state     target;
    logic [5:0] r_round, n_round;
    logic [2:0] r_out_idx, n_out_idx;
    logic       do_push;

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_round   = r_round;
        n_out_idx = r_out_idx;
        target    = r_state;
        do_push   = 1'b0;
        o_cmd     = '0;
        o_cmd.push_src = PUSH_ZERO;
        o_cmd.out_idx  = r_out_idx;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    do_push      = 1'b1;
                    o_cmd.len_en = 1'b1;
                    if (!i_last) begin
                        o_cmd.push_src  = PUSH_DATA;
                        o_cmd.len_bytes = 3'd4;
                        target          = S_IDLE;
                    end else if (i_valid_bytes >= 3'd4) begin
                        // full last word: the marker goes into the next word
                        o_cmd.push_src  = PUSH_DATA;
                        o_cmd.len_bytes = 3'd4;
                        target          = S_PAD80;
                    end else begin
                        o_cmd.push_src  = PUSH_PAD;
                        o_cmd.len_bytes = i_valid_bytes;
                        target          = S_PADZ;
                    end
                end
            end
            S_PAD80: begin
                do_push        = 1'b1;
                o_cmd.push_src = PUSH_MARK;
                target         = S_PADZ;
            end
            S_PADZ: begin
                do_push = 1'b1;
                if (i_stat.fill_is_14) begin
                    o_cmd.push_src = PUSH_LEN_HI;
                    target         = S_LENLO;
                end else begin
                    o_cmd.push_src = PUSH_ZERO;
                    target         = S_PADZ;
                end
            end
            S_LENLO: begin
                do_push        = 1'b1;
                o_cmd.push_src = PUSH_LEN_LO;
                target         = S_EMIT;
            end
            S_ROUNDS: begin
                o_cmd.round_en  = 1'b1;
                o_cmd.round_idx = r_round;
                n_round         = r_round + 6'd1;
                if (r_round == 6'(ROUNDS - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.chain_add = 1'b1;
                n_out_idx       = '0;
                n_state         = r_ret;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == 3'd7) begin
                        o_cmd.chain_reset = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a push that fills the buffer starts a compression
        if (do_push) begin
            o_cmd.push = 1'b1;
            if (i_stat.fill_is_15) begin
                o_cmd.init_vars = 1'b1;
                n_round         = '0;
                n_ret           = target;
                n_state         = S_ROUNDS;
            end else begin
                n_state = target;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_idx   = r_out_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_round   <= '0;
            r_out_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_round   <= n_round;
            r_out_idx <= n_out_idx;
        end
    end

endmodule

// ===== rtl/sha256_dp.sv =====
// ============================================================================
// sha256_dp
// Datapath: block buffer and schedule window, round unit, chaining words, length.
// ============================================================================
module sha256_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha256_pkg::t_dp_cmd  i_cmd,
    output sha256_pkg::t_dp_stat o_stat,
    input  logic [31:0]          i_data_word,
    input  logic [2:0]           i_valid_bytes,
    output logic [31:0]          o_digest_word
);
    import sha256_pkg::*;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    // The block buffer doubles as the rolling schedule window, oldest word at 0
    logic [WORD_W-1:0] r_win   [BLK_WDS];
    logic [WORD_W-1:0] r_vars  [8];
    logic [WORD_W-1:0] r_chain [8];
    logic [LEN_W-1:0]  r_len;
    logic [3:0]        r_fill;

    logic [WORD_W-1:0] push_word, pad_word, sched_w, round_w;
    logic [WORD_W-1:0] s0, s1, bs0, bs1, ch, maj, t1, t2;

    always_comb begin
        case (i_valid_bytes[1:0])
            2'd0:    pad_word = PAD_MARK_WORD;
            2'd1:    pad_word = {i_data_word[31:24], 24'h80_0000};
            2'd2:    pad_word = {i_data_word[31:16], 16'h8000};
            2'd3:    pad_word = {i_data_word[31:8], 8'h80};
            default: pad_word = PAD_MARK_WORD;
        endcase
    end

    always_comb begin
        case (i_cmd.push_src)
            PUSH_DATA:   push_word = i_data_word;
            PUSH_PAD:    push_word = pad_word;
            PUSH_MARK:   push_word = PAD_MARK_WORD;
            PUSH_ZERO:   push_word = '0;
            PUSH_LEN_HI: push_word = r_len[LEN_W-1:WORD_W];
            PUSH_LEN_LO: push_word = r_len[WORD_W-1:0];
            default:     push_word = '0;
        endcase
    end

    // Message schedule: rotate the block through in the first 16 rounds
    assign s0 = rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3);
    assign s1 = rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10);
    assign sched_w = s1 + r_win[9] + s0 + r_win[0];
    assign round_w = (i_cmd.round_idx[5:4] == 2'b00) ? r_win[0] : sched_w;

    // Compression round
    assign bs1 = rotr(r_vars[4], 6) ^ rotr(r_vars[4], 11) ^ rotr(r_vars[4], 25);
    assign bs0 = rotr(r_vars[0], 2) ^ rotr(r_vars[0], 13) ^ rotr(r_vars[0], 22);
    assign ch  = (r_vars[4] & r_vars[5]) ^ (~r_vars[4] & r_vars[6]);
    assign maj = (r_vars[0] & r_vars[1]) ^ (r_vars[0] & r_vars[2]) ^ (r_vars[1] & r_vars[2]);
    assign t1  = r_vars[7] + bs1 + ch + K_TABLE[i_cmd.round_idx] + round_w;
    assign t2  = bs0 + maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.round_en) begin
            for (int i = 0; i < BLK_WDS - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[BLK_WDS-1] <= i_cmd.push ? push_word : round_w;
        end
        if (i_cmd.init_vars) begin
            for (int i = 0; i < 8; i++) begin
                r_vars[i] <= r_chain[i];
            end
        end else if (i_cmd.round_en) begin
            r_vars[0] <= t1 + t2;
            r_vars[1] <= r_vars[0];
            r_vars[2] <= r_vars[1];
            r_vars[3] <= r_vars[2];
            r_vars[4] <= r_vars[3] + t1;
            r_vars[5] <= r_vars[4];
            r_vars[6] <= r_vars[5];
            r_vars[7] <= r_vars[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= H_INIT[i];
            end
            r_len  <= '0;
            r_fill <= '0;
        end else begin
            if (i_cmd.chain_reset) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= H_INIT[i];
                end
            end else if (i_cmd.chain_add) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_vars[i];
                end
            end
            if (i_cmd.chain_reset) begin
                r_len <= '0;
            end else if (i_cmd.len_en) begin
                r_len <= r_len + {58'd0, i_cmd.len_bytes, 3'b000};
            end
            // wraps to zero when the sixteenth word goes in
            if (i_cmd.push) begin
                r_fill <= r_fill + 4'd1;
            end
        end
    end

    assign o_stat.fill_is_14 = (r_fill == 4'd14);
    assign o_stat.fill_is_15 = (r_fill == 4'd15);
    assign o_digest_word     = r_chain[i_cmd.out_idx];

endmodule
